// ===== design/arc_dead_reckoning_odometry_core_defines.svh =====
// Assertion macros used by the odometry core top level.
`ifndef ARC_DEAD_RECKONING_ODOMETRY_CORE_DEFINES_SVH
`define ARC_DEAD_RECKONING_ODOMETRY_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARDO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARDO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ardo_pkg.sv =====
// Shared types, constants and tables for the odometry core.
`default_nettype none

package ardo_pkg;

    // Velocity scale, time units per millisecond count.
    localparam int TIME_SCALE = 1000;
    localparam logic signed [34:0] TIME_SCALE_OP = 35'(TIME_SCALE);

    // Angle constants in Q30 radians.
    localparam logic [37:0]        Q30_TWO_PI_U = 38'd6746518852;
    localparam logic signed [33:0] Q30_TWO_PI   = 34'sd6746518852;
    localparam logic signed [33:0] Q30_PI       = 34'sd3373259426;
    localparam logic signed [33:0] Q30_HALF_PI  = 34'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE      = 34'sd1073741824;

    // Sequencing limits of the shared units.
    localparam logic [4:0] CORDIC_LAST = 5'd29;
    localparam logic [4:0] REDUCE_TOP  = 5'd4;
    localparam logic [5:0] DIV_LAST    = 6'd57;

    // Step counter value at which the sequencer stops counting.
    localparam logic [2:0] STEP_HOLD = 3'd7;

    // Operation codes of an input word.
    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_BASELINE = 2'd1,
        OP_LOAD     = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam logic CFG_LINEAR_OFFSET = 1'b0;
    localparam logic CFG_STRAFE_OFFSET = 1'b1;

    // Top level sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SC1,
        ST_DIVF,
        ST_ARC,
        ST_SC2,
        ST_ROT,
        ST_POSE,
        ST_VMUL,
        ST_VDIV,
        ST_OUT
    } top_state_t;

    // CORDIC unit states.
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_REDUCE,
        CS_WRAP,
        CS_FOLD,
        CS_ITER,
        CS_DONE
    } cord_state_t;

    // Status of an iterative unit seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Arctangent table, Q30 radians.
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/arc_dead_reckoning_odometry_core.sv =====
// Top level of the tracking wheel arc odometry core and its sequencer.
//
// Input channel: in_valid with in_stall; a word carries an operation, the
// sensor sample and a pose to load. The core takes a word in its idle state
// only. Output channel: out_valid with out_stall; every accepted word gives one
// result word with the pose and velocities after the update.
// Configuration: cfg_valid with cfg_ready (always ready), cfg_index picks the
// linear or strafe wheel offset, cfg_data is the value. Write only when idle.
// Operations: baseline latch, pose load and the unused code go straight to the
// output. A sample update runs the shared CORDIC unit, the one-bit-per-cycle
// divider and one registered multiplier under the sequencer; without a heading
// change the first CORDIC pass and the arc-factor division are skipped, as are
// the velocity divisions with no elapsed time. The next word is taken once the
// result sits in the output register.
// Reset clears the pose, velocities, previous sample and wheel offsets.
// A stalled receiver holds the result word; the core may take and process one
// more word, then waits to hand it over until the held word is taken.
`default_nettype none

module arc_dead_reckoning_odometry_core
    import ardo_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         operation,
    input  wire logic signed [31:0] heading,
    input  wire logic signed [31:0] linear_distance,
    input  wire logic signed [31:0] strafe_distance,
    input  wire logic [31:0]        timestamp,
    input  wire logic signed [31:0] load_x,
    input  wire logic signed [31:0] load_y,
    input  wire logic signed [31:0] load_theta,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      pose_x_out,
    output logic signed [31:0]      pose_y_out,
    output logic signed [31:0]      pose_theta_out,
    output logic signed [31:0]      velocity_x,
    output logic signed [31:0]      velocity_y,
    output logic signed [31:0]      velocity_theta
);

`include "arc_dead_reckoning_odometry_core_defines.svh"

    top_state_t state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic [1:0] vidx_reg;
    logic       out_valid_reg;

    logic signed [31:0] lwo_reg;
    logic signed [31:0] swo_reg;
    logic signed [31:0] prev_heading_reg;
    logic signed [31:0] prev_linear_reg;
    logic signed [31:0] prev_strafe_reg;
    logic [31:0]        prev_time_reg;
    logic signed [31:0] pose_x_reg;
    logic signed [31:0] pose_y_reg;
    logic signed [31:0] pose_theta_reg;
    logic signed [31:0] vel_reg [3];

    logic signed [32:0] dh_reg;
    logic signed [32:0] dl_reg;
    logic signed [32:0] ds_reg;
    logic [31:0]        dt_reg;
    logic signed [32:0] hsum_reg;
    logic signed [31:0] h_reg;
    logic signed [31:0] hs_reg;
    logic signed [31:0] f_reg;
    logic signed [35:0] lx_reg;
    logic signed [35:0] ly_reg;
    logic signed [31:0] sn_reg;
    logic signed [31:0] cs_reg;
    logic signed [35:0] gx_reg;
    logic signed [35:0] gy_reg;
    logic signed [69:0] mul_p_reg;

    logic signed [31:0] out_x_reg;
    logic signed [31:0] out_y_reg;
    logic signed [31:0] out_theta_reg;
    logic signed [31:0] out_vx_reg;
    logic signed [31:0] out_vy_reg;
    logic signed [31:0] out_vt_reg;

    logic               in_acc;
    logic               out_load;
    op_t                op;
    logic               cord_start;
    logic signed [37:0] cord_angle;
    unit_stat_t         cord_stat;
    logic signed [31:0] cord_sin;
    logic signed [31:0] cord_cos;
    logic               div_start;
    logic signed [57:0] div_dividend;
    logic signed [33:0] div_divisor;
    unit_stat_t         div_stat;
    logic signed [57:0] div_q;
    logic signed [34:0] mul_a;
    logic signed [34:0] mul_b;
    logic signed [35:0] p_shift;
    logic signed [34:0] hs2;

    // Saturate to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [59:0] v);
        logic signed [31:0] r;
        if (v > 60'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -60'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Clamp the arc factor to plus or minus one in Q30.
    function automatic logic signed [31:0] clamp_unit(input logic signed [57:0] v);
        logic signed [31:0] r;
        if (v > 58'sd1073741824)
        begin
            r = 32'sd1073741824;
        end
        else if (v < -58'sd1073741824)
        begin
            r = -32'sd1073741824;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Clamp a local displacement to plus or minus 2^32.
    function automatic logic signed [35:0] clamp_disp(input logic signed [35:0] v);
        logic signed [35:0] r;
        if (v > 36'sd4294967296)
        begin
            r = 36'sd4294967296;
        end
        else if (v < -36'sd4294967296)
        begin
            r = -36'sd4294967296;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    assign op        = op_t'(operation);
    assign in_acc    = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign p_shift   = $signed(mul_p_reg[65:30]);
    assign hs2       = 35'($signed({hs_reg, 1'b0}));

    assign pose_x_out     = out_x_reg;
    assign pose_y_out     = out_y_reg;
    assign pose_theta_out = out_theta_reg;
    assign velocity_x     = out_vx_reg;
    assign velocity_y     = out_vy_reg;
    assign velocity_theta = out_vt_reg;

    // Shared iterative units.
    ardo_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (cord_angle),
        .stat    (cord_stat),
        .sin_q30 (cord_sin),
        .cos_q30 (cord_cos)
    );

    ardo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (op == OP_SAMPLE) ? ST_SC1 : ST_OUT;
                end
            end
            ST_SC1:
            begin
                if (dh_reg == '0)
                begin
                    state_next = ST_SC2;
                end
                else if (cord_stat.done)
                begin
                    state_next = ST_DIVF;
                end
            end
            ST_DIVF: if (div_stat.done) state_next = ST_ARC;
            ST_ARC:  if (step_reg == 3'd4) state_next = ST_SC2;
            ST_SC2:  if (cord_stat.done) state_next = ST_ROT;
            ST_ROT:  if (step_reg == 3'd4) state_next = ST_POSE;
            ST_POSE: state_next = (dt_reg == '0) ? ST_OUT : ST_VMUL;
            ST_VMUL: state_next = ST_VDIV;
            ST_VDIV:
            begin
                if (div_stat.done)
                begin
                    state_next = (vidx_reg == 2'd2) ? ST_OUT : ST_VMUL;
                end
            end
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
        if (state_next != state_reg)
        begin
            step_next = '0;
        end
        else if (step_reg == STEP_HOLD)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_reg + 3'd1;
        end
    end

    // Sequencer outputs: handshake, unit starts and multiplier operands.
    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        cord_start   = 1'b0;
        cord_angle   = $signed({dh_reg, 5'b00000});
        div_start    = 1'b0;
        div_dividend = 58'($signed({hs_reg, 25'd0}));
        div_divisor  = 34'(dh_reg);
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            ST_SC1:
            begin
                cord_start = (step_reg == '0) && (dh_reg != '0);
            end
            ST_DIVF:
            begin
                div_start = (step_reg == '0);
            end
            ST_ARC:
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        mul_a = 35'(f_reg);
                        mul_b = 35'(ds_reg);
                    end
                    3'd1:
                    begin
                        mul_a = hs2;
                        mul_b = 35'(swo_reg);
                    end
                    3'd2:
                    begin
                        mul_a = 35'(f_reg);
                        mul_b = 35'(dl_reg);
                    end
                    3'd3:
                    begin
                        mul_a = hs2;
                        mul_b = 35'(lwo_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                    end
                endcase
            end
            ST_SC2:
            begin
                cord_start = (step_reg == '0);
                cord_angle = (dh_reg != '0) ? $signed({hsum_reg, 5'b00000})
                                            : $signed({h_reg, 6'b000000});
            end
            ST_ROT:
            begin
                unique case (step_reg)
                    3'd0:
                    begin
                        mul_a = 35'(-lx_reg);
                        mul_b = 35'(sn_reg);
                    end
                    3'd1:
                    begin
                        mul_a = 35'(ly_reg);
                        mul_b = 35'(cs_reg);
                    end
                    3'd2:
                    begin
                        mul_a = 35'(ly_reg);
                        mul_b = 35'(sn_reg);
                    end
                    3'd3:
                    begin
                        mul_a = 35'(lx_reg);
                        mul_b = 35'(cs_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                    end
                endcase
            end
            ST_VMUL, ST_VDIV:
            begin
                unique case (vidx_reg)
                    2'd0:    mul_a = 35'(gx_reg);
                    2'd1:    mul_a = 35'(gy_reg);
                    default: mul_a = 35'(dh_reg);
                endcase
                mul_b        = TIME_SCALE_OP;
                div_start    = (state_reg == ST_VDIV) && (step_reg == '0);
                div_dividend = $signed(mul_p_reg[57:0]);
                div_divisor  = $signed({2'b00, dt_reg});
            end
            default:
            begin
                in_stall = (state_reg != ST_IDLE);
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            vidx_reg         <= '0;
            out_valid_reg    <= 1'b0;
            lwo_reg          <= '0;
            swo_reg          <= '0;
            prev_heading_reg <= '0;
            prev_linear_reg  <= '0;
            prev_strafe_reg  <= '0;
            prev_time_reg    <= '0;
            pose_x_reg       <= '0;
            pose_y_reg       <= '0;
            pose_theta_reg   <= '0;
            vel_reg[0]       <= '0;
            vel_reg[1]       <= '0;
            vel_reg[2]       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;

            // Configuration word.
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_LINEAR_OFFSET: lwo_reg <= $signed(cfg_data);
                    CFG_STRAFE_OFFSET: swo_reg <= $signed(cfg_data);
                endcase
            end

            // Input word.
            if ((state_reg == ST_IDLE) && in_acc)
            begin
                unique case (op)
                    OP_SAMPLE, OP_BASELINE:
                    begin
                        prev_heading_reg <= heading;
                        prev_linear_reg  <= linear_distance;
                        prev_strafe_reg  <= strafe_distance;
                        prev_time_reg    <= timestamp;
                        if (op == OP_SAMPLE)
                        begin
                            pose_theta_reg <= heading;
                        end
                    end
                    OP_LOAD:
                    begin
                        pose_x_reg     <= load_x;
                        pose_y_reg     <= load_y;
                        pose_theta_reg <= load_theta;
                        vel_reg[0]     <= '0;
                        vel_reg[1]     <= '0;
                        vel_reg[2]     <= '0;
                    end
                    OP_NONE:
                    begin
                        pose_theta_reg <= pose_theta_reg;
                    end
                endcase
            end

            // Pose accumulation, and velocities cleared when no time elapsed.
            if (state_reg == ST_POSE)
            begin
                pose_x_reg <= sat32(60'(pose_x_reg) + 60'(gx_reg));
                pose_y_reg <= sat32(60'(pose_y_reg) + 60'(gy_reg));
                vidx_reg   <= '0;
                if (dt_reg == '0)
                begin
                    vel_reg[0] <= '0;
                    vel_reg[1] <= '0;
                    vel_reg[2] <= '0;
                end
            end

            // One velocity per division.
            if ((state_reg == ST_VDIV) && div_stat.done)
            begin
                vel_reg[vidx_reg] <= sat32(60'(div_q));
                vidx_reg          <= vidx_reg + 2'd1;
            end

            // Output register: a new word replaces one taken in the same cycle.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of a sample update and the result word.
    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;

        if ((state_reg == ST_IDLE) && in_acc)
        begin
            dh_reg   <= 33'(heading) - 33'(prev_heading_reg);
            dl_reg   <= 33'(linear_distance) - 33'(prev_linear_reg);
            ds_reg   <= 33'(strafe_distance) - 33'(prev_strafe_reg);
            dt_reg   <= timestamp - prev_time_reg;
            hsum_reg <= 33'(heading) + 33'(prev_heading_reg);
            h_reg    <= heading;
        end

        unique case (state_reg)
            ST_SC1:
            begin
                // Without a heading change the wheel deltas are the displacement.
                if (dh_reg == '0)
                begin
                    lx_reg <= 36'(ds_reg);
                    ly_reg <= 36'(dl_reg);
                end
                else if (cord_stat.done)
                begin
                    hs_reg <= cord_sin;
                end
            end
            ST_DIVF:
            begin
                if (div_stat.done)
                begin
                    f_reg <= clamp_unit(div_q);
                end
            end
            ST_ARC:
            begin
                unique case (step_reg)
                    3'd1:    lx_reg <= p_shift;
                    3'd2:    lx_reg <= clamp_disp(lx_reg + p_shift);
                    3'd3:    ly_reg <= p_shift;
                    3'd4:    ly_reg <= clamp_disp(ly_reg + p_shift);
                    default: ly_reg <= ly_reg;
                endcase
            end
            ST_SC2:
            begin
                if (cord_stat.done)
                begin
                    sn_reg <= cord_sin;
                    cs_reg <= cord_cos;
                end
            end
            ST_ROT:
            begin
                unique case (step_reg)
                    3'd1:    gx_reg <= p_shift;
                    3'd2:    gx_reg <= gx_reg + p_shift;
                    3'd3:    gy_reg <= p_shift;
                    3'd4:    gy_reg <= gy_reg + p_shift;
                    default: gy_reg <= gy_reg;
                endcase
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_x_reg     <= pose_x_reg;
                    out_y_reg     <= pose_y_reg;
                    out_theta_reg <= pose_theta_reg;
                    out_vx_reg    <= vel_reg[0];
                    out_vy_reg    <= vel_reg[1];
                    out_vt_reg    <= vel_reg[2];
                end
            end
            default:
            begin
                f_reg <= f_reg;
            end
        endcase
    end

    // Checks on the sequencer and its shared units.
    `ARDO_ASSERT_SAME(a_cord_start_idle, cord_start, !cord_stat.busy, "CORDIC started while busy")
    `ARDO_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy, "divider started while busy")
    `ARDO_ASSERT_NEXT(a_out_load, out_load, out_valid_reg && (state_reg == ST_IDLE), "result word not presented")
    `ARDO_ASSERT_NEXT(a_zero_dt, (state_reg == ST_POSE) && (dt_reg == '0), (state_reg == ST_OUT) && (vel_reg[0] == '0) && (vel_reg[2] == '0), "zero elapsed time not handled")

endmodule

`default_nettype wire

// ===== design/ardo_cordic.sv =====
// Iterative sine and cosine unit with angle reduction, Q30 in and out.
`default_nettype none

module ardo_cordic
    import ardo_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [37:0] angle,
    output unit_stat_t              stat,
    output logic signed [31:0]      sin_q30,
    output logic signed [31:0]      cos_q30
);

    cord_state_t state_reg, state_next;
    logic [4:0]         cnt_reg;
    logic [37:0]        mag_reg;
    logic               aneg_reg;
    logic signed [33:0] r_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic               flip_reg;

    logic [37:0]        step_const;
    logic signed [33:0] r_signed;
    logic signed [33:0] r_wrap;
    logic signed [33:0] r_fold;
    logic               fold_flip;
    logic signed [33:0] x_shift;
    logic signed [33:0] y_shift;
    logic signed [33:0] atan_val;
    logic signed [33:0] cos_pre;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:   if (start) state_next = CS_REDUCE;
            CS_REDUCE: if (cnt_reg == '0) state_next = CS_WRAP;
            CS_WRAP:   state_next = CS_FOLD;
            CS_FOLD:   state_next = CS_ITER;
            CS_ITER:   if (cnt_reg == CORDIC_LAST) state_next = CS_DONE;
            CS_DONE:   state_next = CS_IDLE;
            default:   state_next = CS_IDLE;
        endcase
    end

    // Status outputs.
    always_comb
    begin
        stat.busy = (state_reg != CS_IDLE);
        stat.done = (state_reg == CS_DONE);
    end

    // Step arithmetic: reduction subtrahend, wrap, fold and rotation shifts.
    always_comb
    begin
        step_const = Q30_TWO_PI_U << cnt_reg[2:0];
        r_signed   = $signed({1'b0, mag_reg[32:0]});
        if (aneg_reg)
        begin
            r_signed = -r_signed;
        end
        r_wrap = r_signed;
        if (r_signed > Q30_PI)
        begin
            r_wrap = r_signed - Q30_TWO_PI;
        end
        else if (r_signed < -Q30_PI)
        begin
            r_wrap = r_signed + Q30_TWO_PI;
        end
        r_fold    = r_reg;
        fold_flip = 1'b0;
        if (r_reg > Q30_HALF_PI)
        begin
            r_fold    = Q30_PI - r_reg;
            fold_flip = 1'b1;
        end
        else if (r_reg < -Q30_HALF_PI)
        begin
            r_fold    = -Q30_PI - r_reg;
            fold_flip = 1'b1;
        end
        x_shift  = x_reg >>> cnt_reg;
        y_shift  = y_reg >>> cnt_reg;
        atan_val = $signed({2'b00, atan_q30(cnt_reg)});
    end

    // Results, with the fold sign applied and clamped to one.
    always_comb
    begin
        cos_pre = flip_reg ? -x_reg : x_reg;
        if (y_reg > Q30_ONE)
        begin
            sin_q30 = 32'(Q30_ONE);
        end
        else if (y_reg < -Q30_ONE)
        begin
            sin_q30 = 32'(-Q30_ONE);
        end
        else
        begin
            sin_q30 = 32'(y_reg);
        end
        if (cos_pre > Q30_ONE)
        begin
            cos_q30 = 32'(Q30_ONE);
        end
        else if (cos_pre < -Q30_ONE)
        begin
            cos_q30 = 32'(-Q30_ONE);
        end
        else
        begin
            cos_q30 = 32'(cos_pre);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                CS_IDLE:   if (start) cnt_reg <= REDUCE_TOP;
                CS_REDUCE: cnt_reg <= cnt_reg - 5'd1;
                CS_FOLD:   cnt_reg <= '0;
                CS_ITER:   cnt_reg <= cnt_reg + 5'd1;
                default:   cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    mag_reg  <= angle[37] ? 38'(-angle) : 38'(angle);
                    aneg_reg <= angle[37];
                end
            end
            CS_REDUCE:
            begin
                if (mag_reg >= step_const)
                begin
                    mag_reg <= mag_reg - step_const;
                end
            end
            CS_WRAP:
            begin
                r_reg <= r_wrap;
            end
            CS_FOLD:
            begin
                r_reg    <= r_fold;
                flip_reg <= fold_flip;
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
            end
            CS_ITER:
            begin
                if (r_reg >= 0)
                begin
                    x_reg <= x_reg - y_shift;
                    y_reg <= y_reg + x_shift;
                    r_reg <= r_reg - atan_val;
                end
                else
                begin
                    x_reg <= x_reg + y_shift;
                    y_reg <= y_reg - x_shift;
                    r_reg <= r_reg + atan_val;
                end
            end
            default:
            begin
                r_reg <= r_reg;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/ardo_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module ardo_div
    import ardo_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [57:0] dividend,
    input  wire logic signed [33:0] divisor,
    output unit_stat_t              stat,
    output logic signed [57:0]      quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [57:0] n_reg;
    logic [33:0] d_reg;
    logic [33:0] rem_reg;
    logic        neg_reg;
    logic [34:0] shifted;
    logic        fits;

    // Trial subtraction of one restoring step.
    always_comb
    begin
        shifted = {rem_reg, n_reg[57]};
        fits    = (shifted >= {1'b0, d_reg});
    end

    always_comb
    begin
        stat.busy = busy_reg;
        stat.done = done_reg;
        quotient  = neg_reg ? -$signed(n_reg) : $signed(n_reg);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == DIV_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Magnitudes, remainder and quotient bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= dividend[57] ? 58'(-dividend) : 58'(dividend);
            d_reg   <= divisor[33] ? 34'(-divisor) : 34'(divisor);
            rem_reg <= '0;
            neg_reg <= dividend[57] ^ divisor[33];
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= 34'(shifted - {1'b0, d_reg});
                n_reg   <= {n_reg[56:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[33:0];
                n_reg   <= {n_reg[56:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire
